// File: rtl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types, constants and helpers of the text console with cursor scroll.
// ----------------------------------------------------------------------------
package tccs_pkg;

    localparam int MAX_COLS   = 128;
    localparam int MAX_ROWS   = 64;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int DEPTH      = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int PIX_W      = 13;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [7:0] SPACE   = 8'h20;
    localparam logic [7:0] NEWLINE = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd3;

    typedef enum logic [1:0] {
        K_READ,
        K_NUL,
        K_NL,
        K_CHAR
    } t_kind;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PRE,
        S_WR,
        S_CLR,
        S_RDW,
        S_DONE
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] glyph;
        logic [2:0]  len;
        logic [5:0]  read_row;
        logic [6:0]  read_col;
    } t_entry;

    typedef struct packed {
        logic [COL_W:0] cols;
        logic [ROW_W:0] rows;
        logic [11:0]    origin_x;
        logic [11:0]    origin_y;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic init;
        logic idle;
    } t_be_stat;

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] vis);
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, vis};
        if (sum >= (ROW_W+1)'(MAX_ROWS)) begin
            sum = sum - (ROW_W+1)'(MAX_ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow * MAX_COLS) + ADDR_W'(col);
    endfunction

endpackage

// File: rtl/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console: puts characters at a wrapping cursor with ring scroll and
// reads back stored cells.
//
//   channel   direction  handshake              payload
//   input     in         i_in_valid/o_in_stall  op, char_bytes, char_len,
//                                               read_row, read_col
//   result    out        o_out_valid/i_out_stall draw_valid, pixel_x, pixel_y,
//                                               glyph_bytes, glyph_len,
//                                               scrolled, cell_byte
//   config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// one word at a time through the engine: an in-range read passes S_RDW, a
// character S_PRE and S_WR, a newline S_PRE, a null word or out-of-range
// read neither; each scroll clears all MAX_COLS cells of the new bottom row
// through the single store write port; after reset the store is swept to
// spaces; up to two words queue meanwhile
// a stalled result sits in the output register while the next word is queued
// ----------------------------------------------------------------------------
module text_console_cursor_scroll (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [31:0] i_char_bytes,
    input  logic [2:0]  i_char_len,
    input  logic [5:0]  i_read_row,
    input  logic [6:0]  i_read_col,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_draw_valid,
    output logic [12:0] o_pixel_x,
    output logic [12:0] o_pixel_y,
    output logic [31:0] o_glyph_bytes,
    output logic [2:0]  o_glyph_len,
    output logic        o_scrolled,
    output logic [7:0]  o_cell_byte
);
    import tccs_pkg::*;

    logic [7:0]  r_columns;
    logic [6:0]  r_rows;
    logic [11:0] r_origin_x;
    logic [11:0] r_origin_y;

    t_cfg     cfg;
    t_entry   f_entry;
    t_entry   q_entry;
    t_q_stat  q_stat;
    t_be_stat be_stat;
    logic     q_push;
    logic     q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns  <= 8'd80;
            r_rows     <= 7'd25;
            r_origin_x <= 12'd50;
            r_origin_y <= 12'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COLUMNS:  r_columns  <= i_cfg_data[7:0];
                CFG_ROWS:     r_rows     <= i_cfg_data[6:0];
                CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                default:      r_columns  <= r_columns;
            endcase
        end
    end

    always_comb begin
        if (r_columns == 8'd0) begin
            cfg.cols = (COL_W+1)'(1);
        end else if (32'(r_columns) > MAX_COLS) begin
            cfg.cols = (COL_W+1)'(MAX_COLS);
        end else begin
            cfg.cols = (COL_W+1)'(r_columns);
        end
        if (r_rows == 7'd0) begin
            cfg.rows = (ROW_W+1)'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            cfg.rows = (ROW_W+1)'(MAX_ROWS);
        end else begin
            cfg.rows = (ROW_W+1)'(r_rows);
        end
        cfg.origin_x = r_origin_x;
        cfg.origin_y = r_origin_y;
    end

    tccs_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_char_bytes (i_char_bytes),
        .i_char_len   (i_char_len),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_q_stat     (q_stat),
        .o_push       (q_push),
        .o_entry      (f_entry)
    );

    tccs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (f_entry),
        .i_pop   (q_pop),
        .o_entry (q_entry),
        .o_stat  (q_stat)
    );

    tccs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_entry     (q_entry),
        .i_q_stat      (q_stat),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_draw_valid  (o_draw_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_glyph_bytes (o_glyph_bytes),
        .o_glyph_len   (o_glyph_len),
        .o_scrolled    (o_scrolled),
        .o_cell_byte   (o_cell_byte),
        .o_stat        (be_stat)
    );

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (!q_stat.empty && be_stat.idle))
        else $error("queue popped while empty or engine busy");

    a_no_result_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        be_stat.init |-> !o_out_valid)
        else $error("result word during store sweep");

    a_draw_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_draw_valid) |-> (o_glyph_len != 3'd0 && o_cell_byte == 8'd0))
        else $error("draw word with empty glyph or cell byte");

    a_nodraw_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_draw_valid) |->
            (o_pixel_x == 13'd0 && o_pixel_y == 13'd0 && o_glyph_len == 3'd0))
        else $error("non-draw word carries draw fields");

endmodule

// File: rtl/tccs_front.sv
// ----------------------------------------------------------------------------
// tccs_front
// Input side: sorts each word into read, null, newline or character and
// prepares the clamped length and masked glyph for the queue.
// ----------------------------------------------------------------------------
module tccs_front (
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_op,
    input  logic [31:0]      i_char_bytes,
    input  logic [2:0]       i_char_len,
    input  logic [5:0]       i_read_row,
    input  logic [6:0]       i_read_col,
    input  tccs_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output tccs_pkg::t_entry o_entry
);
    import tccs_pkg::*;

    logic [7:0]  lead;
    logic [2:0]  len_c;
    logic [31:0] glyph;
    t_kind       kind;

    assign lead = i_char_bytes[7:0];

    always_comb begin
        if (i_char_len == 3'd0) begin
            len_c = 3'd1;
        end else if (i_char_len > 3'd4) begin
            len_c = 3'd4;
        end else begin
            len_c = i_char_len;
        end
    end

    always_comb begin
        unique case (len_c)
            3'd1:    glyph = {24'd0, i_char_bytes[7:0]};
            3'd2:    glyph = {16'd0, i_char_bytes[15:0]};
            3'd3:    glyph = {8'd0, i_char_bytes[23:0]};
            default: glyph = i_char_bytes;
        endcase
    end

    always_comb begin
        priority if (i_op) begin
            kind = K_READ;
        end else if (lead == 8'd0) begin
            kind = K_NUL;
        end else if (lead == NEWLINE) begin
            kind = K_NL;
        end else begin
            kind = K_CHAR;
        end
    end

    assign o_entry.kind     = kind;
    assign o_entry.glyph    = glyph;
    assign o_entry.len      = len_c;
    assign o_entry.read_row = i_read_row;
    assign o_entry.read_col = i_read_col;

    assign o_in_stall = i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

endmodule

// File: rtl/tccs_fifo.sv
// ----------------------------------------------------------------------------
// tccs_fifo
// Short queue of classified words between the input side and the engine.
// ----------------------------------------------------------------------------
module tccs_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tccs_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output tccs_pkg::t_entry  o_entry,
    output tccs_pkg::t_q_stat o_stat
);
    import tccs_pkg::*;

    t_entry                r_slot [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_count;
    logic [FIFO_PTR_W-1:0] n_wr_ptr;
    logic [FIFO_PTR_W-1:0] n_rd_ptr;
    logic [FIFO_PTR_W:0]   n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry      = r_slot[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (FIFO_PTR_W+1)'(FIFO_DEPTH));

endmodule

// File: rtl/tccs_back.sv
// ----------------------------------------------------------------------------
// tccs_back
// Console engine: character store, cursor, ring offset, scroll clearing and
// the registered result word.
// ----------------------------------------------------------------------------
module tccs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tccs_pkg::t_cfg     i_cfg,
    input  tccs_pkg::t_entry   i_q_entry,
    input  tccs_pkg::t_q_stat  i_q_stat,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_draw_valid,
    output logic [12:0]        o_pixel_x,
    output logic [12:0]        o_pixel_y,
    output logic [31:0]        o_glyph_bytes,
    output logic [2:0]         o_glyph_len,
    output logic               o_scrolled,
    output logic [7:0]         o_cell_byte,
    output tccs_pkg::t_be_stat o_stat
);
    import tccs_pkg::*;

    logic [7:0] mem [DEPTH];

    t_state            r_state, n_state;
    t_state            r_ret, n_ret;
    logic [ADDR_W-1:0] r_sweep, n_sweep;
    logic [COL_W-1:0]  r_clr_col, n_clr_col;
    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [ROW_W-1:0]  r_top, n_top;
    logic [ROW_W-1:0]  r_bottom, n_bottom;
    t_entry            r_item, n_item;
    logic              r_draw, n_draw;
    logic [PIX_W-1:0]  r_px, n_px;
    logic [PIX_W-1:0]  r_py, n_py;
    logic              r_scr, n_scr;
    logic [7:0]        r_cell, n_cell;
    logic [7:0]        r_rdata;

    logic              r_o_valid, n_o_valid;
    logic              r_o_draw;
    logic [PIX_W-1:0]  r_o_px;
    logic [PIX_W-1:0]  r_o_py;
    logic [31:0]       r_o_glyph;
    logic [2:0]        r_o_len;
    logic              r_o_scr;
    logic [7:0]        r_o_cell;
    logic              load_out;

    logic              we;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic              do_nr;
    t_state            nr_ret;
    logic [ROW_W:0]    row_inc;
    logic [COL_W:0]    col_inc;
    logic              nr_scroll;
    logic [ROW_W-1:0]  top_inc;
    logic [ROW_W-1:0]  last_row;
    logic              out_free;
    logic              rd_in_range;

    assign row_inc   = {1'b0, r_cur_row} + 1'b1;
    assign col_inc   = {1'b0, r_cur_col} + 1'b1;
    assign nr_scroll = (row_inc >= i_cfg.rows);
    assign top_inc   = (r_top == ROW_W'(MAX_ROWS - 1)) ? '0 : r_top + 1'b1;
    assign last_row  = ROW_W'(i_cfg.rows - 1'b1);
    assign out_free  = !r_o_valid || !i_out_stall;
    assign rd_in_range = (32'(i_q_entry.read_row) < 32'(i_cfg.rows)) &&
                         (32'(i_q_entry.read_col) < 32'(i_cfg.cols));

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_sweep   = r_sweep;
        n_clr_col = r_clr_col;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_top     = r_top;
        n_bottom  = r_bottom;
        n_item    = r_item;
        n_draw    = r_draw;
        n_px      = r_px;
        n_py      = r_py;
        n_scr     = r_scr;
        n_cell    = r_cell;
        n_o_valid = r_o_valid && i_out_stall;
        load_out  = 1'b0;
        o_pop     = 1'b0;
        we        = 1'b0;
        wr_addr   = '0;
        wr_data   = SPACE;
        rd_en     = 1'b0;
        rd_addr   = '0;
        do_nr     = 1'b0;
        nr_ret    = S_DONE;

        unique case (r_state)
            S_INIT: begin
                we      = 1'b1;
                wr_addr = r_sweep;
                if (r_sweep == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop  = 1'b1;
                    n_item = i_q_entry;
                    n_draw = 1'b0;
                    n_px   = '0;
                    n_py   = '0;
                    n_scr  = 1'b0;
                    n_cell = 8'd0;
                    unique case (i_q_entry.kind)
                        K_READ: begin
                            if (rd_in_range) begin
                                rd_en   = 1'b1;
                                rd_addr = cell_addr(
                                    phys_row(r_top, ROW_W'(i_q_entry.read_row)),
                                    COL_W'(i_q_entry.read_col));
                                n_state = S_RDW;
                            end else begin
                                n_cell  = SPACE;
                                n_state = S_DONE;
                            end
                        end
                        K_NUL: begin
                            n_state = S_DONE;
                        end
                        K_NL, K_CHAR: begin
                            if ({1'b0, r_cur_row} >= i_cfg.rows) begin
                                n_cur_row = last_row;
                            end
                            n_state = S_PRE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_PRE: begin
                if (r_item.kind == K_NL) begin
                    do_nr  = 1'b1;
                    nr_ret = S_DONE;
                end else if ({1'b0, r_cur_col} >= i_cfg.cols) begin
                    do_nr  = 1'b1;
                    nr_ret = S_WR;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                we      = 1'b1;
                wr_addr = cell_addr(phys_row(r_top, r_cur_row), r_cur_col);
                wr_data = r_item.glyph[7:0];
                n_draw  = 1'b1;
                n_px    = PIX_W'(14'(i_cfg.origin_x) + 14'({r_cur_col, 3'b000}));
                n_py    = PIX_W'(14'(i_cfg.origin_y) + 14'({r_cur_row, 4'b0000}));
                if (col_inc >= i_cfg.cols) begin
                    do_nr  = 1'b1;
                    nr_ret = S_DONE;
                end else begin
                    n_cur_col = col_inc[COL_W-1:0];
                    n_state   = S_DONE;
                end
            end
            S_CLR: begin
                we      = 1'b1;
                wr_addr = cell_addr(r_bottom, r_clr_col);
                if (r_clr_col == COL_W'(MAX_COLS - 1)) begin
                    n_state = r_ret;
                end else begin
                    n_clr_col = r_clr_col + 1'b1;
                end
            end
            S_RDW: begin
                n_cell  = r_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    load_out  = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // cursor to next row, scrolling past the last row in use
        if (do_nr) begin
            n_cur_col = '0;
            if (nr_scroll) begin
                n_top     = top_inc;
                n_bottom  = phys_row(top_inc, last_row);
                n_cur_row = last_row;
                n_scr     = 1'b1;
                n_clr_col = '0;
                n_ret     = nr_ret;
                n_state   = S_CLR;
            end else begin
                n_cur_row = row_inc[ROW_W-1:0];
                n_state   = nr_ret;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_ret     <= S_DONE;
            r_sweep   <= '0;
            r_clr_col <= '0;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_top     <= '0;
            r_bottom  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_sweep   <= n_sweep;
            r_clr_col <= n_clr_col;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_top     <= n_top;
            r_bottom  <= n_bottom;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_draw <= n_draw;
        r_px   <= n_px;
        r_py   <= n_py;
        r_scr  <= n_scr;
        r_cell <= n_cell;
        if (load_out) begin
            r_o_draw  <= r_draw;
            r_o_px    <= r_px;
            r_o_py    <= r_py;
            r_o_glyph <= r_draw ? r_item.glyph : 32'd0;
            r_o_len   <= r_draw ? r_item.len : 3'd0;
            r_o_scr   <= r_scr;
            r_o_cell  <= r_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_draw_valid  = r_o_draw;
    assign o_pixel_x     = r_o_px;
    assign o_pixel_y     = r_o_py;
    assign o_glyph_bytes = r_o_glyph;
    assign o_glyph_len   = r_o_len;
    assign o_scrolled    = r_o_scr;
    assign o_cell_byte   = r_o_cell;
    assign o_stat.init   = (r_state == S_INIT);
    assign o_stat.idle   = (r_state == S_IDLE);

endmodule

// File: bench/text_console_cursor_scroll_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_tb
// Drives put and read words into the text console under a range of console
// geometries and origins, including out-of-range register values, and
// compares every result word against a cycle-free mirror of the console
// store, cursor and scroll offset. Sender gaps, receiver stalls and two long
// receiver hold-offs per run exercise the handshakes.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_tb;
    import tccs_pkg::*;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;
    localparam int   HOLD_CYCLES  = 300;
    localparam int   LIMIT_CYCLES = 3_000_000;
    localparam int   PHASES       = 8;
    localparam int   PHASE_WORDS  = 180;

    typedef struct packed {
        logic        op;
        logic [31:0] bytes;
        logic [2:0]  len;
        logic [5:0]  row;
        logic [6:0]  col;
    } t_word;

    typedef struct packed {
        logic        draw;
        logic [12:0] px;
        logic [12:0] py;
        logic [31:0] glyph;
        logic [2:0]  glen;
        logic        scrolled;
        logic [7:0]  stored;
    } t_result;

    class t_console_mirror;
        logic [7:0]  cells [DEPTH];
        int unsigned cur_col;
        int unsigned cur_row;
        int unsigned top_ofs;
        logic [7:0]  reg_cols;
        logic [6:0]  reg_rows;
        logic [11:0] reg_ox;
        logic [11:0] reg_oy;
        t_result     awaited [$];
        int          mismatches;
        int          seen;

        function new();
            reg_cols = 8'd80;
            reg_rows = 7'd25;
            reg_ox = 12'd50;
            reg_oy = 12'd100;
            foreach (cells[k]) cells[k] = SPACE;
            cur_col = 0;
            cur_row = 0;
            top_ofs = 0;
            mismatches = 0;
            seen = 0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        function void set_reg(logic [1:0] idx, logic [11:0] data);
            case (idx)
                CFG_COLUMNS:  reg_cols = data[7:0];
                CFG_ROWS:     reg_rows = data[6:0];
                CFG_ORIGIN_X: reg_ox = data;
                CFG_ORIGIN_Y: reg_oy = data;
                default: ;
            endcase
        endfunction

        function int unsigned cols_in_use();
            if (reg_cols == 0) return 1;
            if (reg_cols > MAX_COLS) return MAX_COLS;
            return reg_cols;
        endfunction

        function int unsigned rows_in_use();
            if (reg_rows == 0) return 1;
            if (reg_rows > MAX_ROWS) return MAX_ROWS;
            return reg_rows;
        endfunction

        function int unsigned cell_index(int unsigned vis_row, int unsigned col);
            return ((top_ofs + vis_row) % MAX_ROWS) * MAX_COLS + col;
        endfunction

        // cursor to the next row, scrolling the ring when it runs off the bottom
        function logic advance_row();
            int unsigned r;
            int unsigned bottom;
            r = rows_in_use();
            cur_col = 0;
            cur_row++;
            if (cur_row >= r) begin
                top_ofs = (top_ofs + 1) % MAX_ROWS;
                bottom = (top_ofs + r - 1) % MAX_ROWS;
                for (int k = 0; k < MAX_COLS; k++) cells[bottom * MAX_COLS + k] = SPACE;
                cur_row = r - 1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void apply_word(t_word w);
            t_result     e;
            int unsigned c;
            int unsigned r;
            int unsigned len;
            logic [7:0]  lead;
            e = '0;
            c = cols_in_use();
            r = rows_in_use();
            lead = w.bytes[7:0];
            if (w.op == OP_READ) begin
                e.stored = SPACE;
                if (w.row < r && w.col < c) e.stored = cells[cell_index(w.row, w.col)];
            end else if (lead != 8'h00) begin
                if (cur_row >= r) cur_row = r - 1;
                if (lead == NEWLINE) begin
                    e.scrolled = advance_row();
                end else begin
                    len = w.len;
                    if (len < 1) len = 1;
                    if (len > 4) len = 4;
                    if (cur_col >= c) e.scrolled = advance_row();
                    cells[cell_index(cur_row, cur_col)] = lead;
                    e.draw = 1'b1;
                    e.px = 13'(reg_ox + cur_col * 8);
                    e.py = 13'(reg_oy + cur_row * 16);
                    e.glyph = (len == 4) ? w.bytes : (w.bytes & ((32'h1 << (len * 8)) - 1));
                    e.glen = 3'(len);
                    cur_col++;
                    if (cur_col >= c) begin
                        if (advance_row()) e.scrolled = 1'b1;
                    end
                end
            end
            awaited.push_back(e);
        endfunction

        task check_word(t_result got);
            t_result want;
            seen++;
            if (awaited.size() == 0) begin
                report($sformatf("word %0d arrived with nothing awaited: %h", seen, got));
                return;
            end
            want = awaited.pop_front();
            if (got.draw !== want.draw)
                report($sformatf("word %0d draw_valid %b want %b", seen, got.draw, want.draw));
            if (got.px !== want.px)
                report($sformatf("word %0d pixel_x %0d want %0d", seen, got.px, want.px));
            if (got.py !== want.py)
                report($sformatf("word %0d pixel_y %0d want %0d", seen, got.py, want.py));
            if (got.glyph !== want.glyph)
                report($sformatf("word %0d glyph_bytes %h want %h", seen, got.glyph, want.glyph));
            if (got.glen !== want.glen)
                report($sformatf("word %0d glyph_len %0d want %0d", seen, got.glen, want.glen));
            if (got.scrolled !== want.scrolled)
                report($sformatf("word %0d scrolled %b want %b", seen, got.scrolled,
                                 want.scrolled));
            if (got.stored !== want.stored)
                report($sformatf("word %0d cell_byte %h want %h", seen, got.stored,
                                 want.stored));
        endtask

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_COLUMNS;
    logic [11:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_op = OP_PUT;
    logic [31:0] i_char_bytes = '0;
    logic [2:0]  i_char_len = '0;
    logic [5:0]  i_read_row = '0;
    logic [6:0]  i_read_col = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_draw_valid;
    logic [12:0] o_pixel_x;
    logic [12:0] o_pixel_y;
    logic [31:0] o_glyph_bytes;
    logic [2:0]  o_glyph_len;
    logic        o_scrolled;
    logic [7:0]  o_cell_byte;

    t_console_mirror mirror;
    int unsigned   send_gap_pct = 0;
    int unsigned   stall_pct = 0;
    int unsigned   holds_asked = 0;
    int unsigned   holds_given = 0;
    int unsigned   hold_left = 0;
    int unsigned   cycles = 0;

    text_console_cursor_scroll i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_char_bytes  (i_char_bytes),
        .i_char_len    (i_char_len),
        .i_read_row    (i_read_row),
        .i_read_col    (i_read_col),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_draw_valid  (o_draw_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_glyph_bytes (o_glyph_bytes),
        .o_glyph_len   (o_glyph_len),
        .o_scrolled    (o_scrolled),
        .o_cell_byte   (o_cell_byte)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("text_console_cursor_scroll_tb failed");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is asked for
    always @(posedge i_clk) begin
        if (holds_asked != holds_given) begin
            holds_given <= holds_given + 1;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            mirror.check_word('{o_draw_valid, o_pixel_x, o_pixel_y, o_glyph_bytes,
                                o_glyph_len, o_scrolled, o_cell_byte});
        end
    end

    function automatic t_word put_char(logic [31:0] bytes, logic [2:0] len);
        t_word w;
        w = '{OP_PUT, bytes, len, 6'($urandom), 7'($urandom)};
        return w;
    endfunction

    function automatic t_word read_cell(logic [5:0] row, logic [6:0] col);
        t_word w;
        w = '{OP_READ, 32'($urandom), 3'($urandom), row, col};
        return w;
    endfunction

    task automatic send_word(t_word w);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= w.op;
        i_char_bytes <= w.bytes;
        i_char_len <= w.len;
        i_read_row <= w.row;
        i_read_col <= w.col;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        mirror.apply_word(w);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (mirror.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic program_console(logic [11:0] cols, logic [11:0] rows,
                                   logic [11:0] ox, logic [11:0] oy);
        logic [11:0] vals [4];
        logic [1:0]  idx [4];
        vals = '{cols, rows, ox, oy};
        idx = '{CFG_COLUMNS, CFG_ROWS, CFG_ORIGIN_X, CFG_ORIGIN_Y};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            mirror.set_reg(idx[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_word random_word();
        int unsigned pick;
        logic [7:0]  lead;
        logic [2:0]  len;
        pick = $urandom_range(99);
        if (pick < 8) return put_char({24'($urandom), NEWLINE}, 3'($urandom));
        if (pick < 12) return put_char({24'($urandom), 8'h00}, 3'($urandom));
        if (pick < 30) begin
            if ($urandom_range(99) < 70)
                return read_cell(6'($urandom_range(mirror.rows_in_use() - 1)),
                                 7'($urandom_range(mirror.cols_in_use() - 1)));
            return read_cell(6'($urandom), 7'($urandom));
        end
        lead = 8'($urandom_range(255, 1));
        if (lead == NEWLINE) lead = 8'h41;
        len = ($urandom_range(99) < 80) ? 3'($urandom_range(4, 1)) : 3'($urandom);
        return put_char({24'($urandom), lead}, len);
    endfunction

    initial begin
        int unsigned ph_cols [PHASES];
        int unsigned ph_rows [PHASES];
        int unsigned ph_ox [PHASES];
        int unsigned ph_oy [PHASES];
        mirror = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: reads, null, length clamps, wide glyphs, newlines
        send_word(read_cell(6'd0, 7'd0));
        send_word(read_cell(6'd63, 7'd127));
        send_word(put_char(32'hFFFF_FF00, 3'd4));
        send_word(put_char(32'h0000_0041, 3'd1));
        send_word(put_char(32'hFFFF_FF42, 3'd0));
        send_word(put_char(32'hFFFF_FFFF, 3'd7));
        send_word(put_char(32'h0000_A9C3, 3'd5));
        send_word(put_char(32'h0098_9FF0, 3'd3));
        send_word(put_char(32'hFFFF_FF0A, 3'd0));
        send_word(put_char(32'h0000_0080, 3'd2));
        send_word(put_char(32'h0000_000A, 3'd1));
        send_word(read_cell(6'd0, 7'd0));
        send_word(read_cell(6'd0, 7'd5));
        send_word(read_cell(6'd1, 7'd0));
        send_word(read_cell(6'd24, 7'd79));
        send_word(read_cell(6'd25, 7'd0));
        send_word(read_cell(6'd0, 7'd80));
        drain();

        // shrink under a live cursor: row saturates, column wraps and scrolls
        program_console(12'd2, 12'd1, 12'd4095, 12'd4095);
        send_word(put_char(32'h0000_005A, 3'd1));
        send_word(put_char(32'h0000_0059, 3'd1));
        send_word(put_char(32'h0000_000A, 3'd1));
        send_word(put_char(32'h0000_0058, 3'd1));
        send_word(read_cell(6'd0, 7'd0));
        send_word(read_cell(6'd0, 7'd1));
        send_word(read_cell(6'd1, 7'd0));
        drain();

        ph_cols = '{8, 1, 128, 0, 255, $urandom_range(12, 2), $urandom_range(40, 1), 3};
        ph_rows = '{4, 1, 64, 0, 127, $urandom_range(6, 1), $urandom_range(30, 2), 2};
        ph_ox = '{17, 0, 4095, 0, 4095, $urandom_range(4095), $urandom_range(4095),
                  $urandom_range(4095)};
        ph_oy = '{33, 0, 4095, 4095, 0, $urandom_range(4095), $urandom_range(4095),
                  $urandom_range(4095)};
        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 53; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 53; end
                default: begin send_gap_pct = 24; stall_pct = 24; end
            endcase
            program_console(12'(ph_cols[p]), 12'(ph_rows[p]), 12'(ph_ox[p]), 12'(ph_oy[p]));
            if (p == 2 || p == 5) holds_asked = holds_asked + 1;
            for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word());
            drain();
        end

        repeat (MAX_COLS + 16) @(posedge i_clk);
        if (mirror.outstanding() != 0)
            mirror.report($sformatf("%0d results never arrived", mirror.outstanding()));
        if (mirror.mismatches == 0) begin
            $display("text_console_cursor_scroll_tb passed");
        end else begin
            $display("text_console_cursor_scroll_tb failed");
        end
        $finish;
    end

endmodule
